// ===== design/pip_pkg.sv =====
// shared types and constants for the point-in-polygon crossing test
// no dependencies
package pip_pkg;

  // default coordinate width, signed q16.16
  localparam int COORD_BITS_DEF = 32;

  // edge queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;

  // register stages inside one edge test lane
  localparam int EDGE_LATENCY = 4;

  // per-entry control: polygon boundaries and the class of each edge
  typedef struct packed {
    logic first;
    logic last;
    logic count0;
    logic mul0;
    logic count1;
    logic mul1;
  } entry_ctl_t;

endpackage

// ===== design/point_in_polygon_crossing_test_unit.sv =====
// top level of the point-in-polygon crossing test
// depends on pip_pkg, pip_front, pip_queue, pip_back (and pip_edge_test below it)
//
// Streams the vertices of one polygon, one transaction per vertex, and returns
// the even-odd inside flag on the closing vertex (is_last = 1). The first
// vertex of a polygon also carries the test point; point fields on later
// vertices are ignored. Every later vertex tests the edge from the previous one,
// and the closing vertex also tests the edge back to the first vertex. Edges
// are ordered by y, counted when the test y lies in their inclusive y span and
// they are not horizontal there, and the test x is at or right of both ends or
// the crossing lies strictly left of it; the crossing test is an exact
// cross-multiplication, no division. Throughput is one vertex per clock while
// the edge queue is not full: the front classifies one vertex a cycle and the
// back has edge test lanes u_lane0 and u_lane1, so a closing vertex with both its
// edges goes through as fast as any other. Each lane multiplies with four half-width
// partial products per product. A closing vertex passes the edge queue, the four
// lane stages and then the result register; stalls hold it. The four-entry
// edge queue lets the vertex side keep going while a result waits on
// result_ready; once it fills, vertex_ready drops until the result is taken.
module point_in_polygon_crossing_test_unit #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vertex_valid,
  output logic                          vertex_ready,
  input  logic signed [COORD_BITS-1:0]  vertex_x,
  input  logic signed [COORD_BITS-1:0]  vertex_y,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic                          is_last,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          inside_res
);
  import pip_pkg::*;

  localparam int DATA_W = 10 * COORD_BITS;

  // front to queue
  logic              push;
  entry_ctl_t        push_ctl;
  logic [DATA_W-1:0] push_data;
  logic              queue_full;

  // queue to back
  logic              pop;
  logic              head_valid;
  entry_ctl_t        head_ctl;
  logic [DATA_W-1:0] head_data;

  // vertex intake: holds the first vertex, previous vertex and test point,
  // orders each edge by y and sorts it into skip, count-at-once or exact test
  pip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .point_x      (point_x),
    .point_y      (point_y),
    .is_last      (is_last),
    .queue_full   (queue_full),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_data    (push_data)
  );

  // one entry per vertex: test point plus up to two ordered edges
  pip_queue #(.WIDTH(DATA_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_data  (head_data)
  );

  // exact crossing tests, parity per polygon, registered result
  pip_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_ctl     (head_ctl),
    .head_data    (head_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .inside_res   (inside_res)
  );

endmodule

// ===== design/pip_front.sv =====
// front part: vertex intake, polygon state and edge classification
// depends on pip_pkg
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vertex_valid,
  output logic                          vertex_ready,
  input  logic signed [COORD_BITS-1:0]  vertex_x,
  input  logic signed [COORD_BITS-1:0]  vertex_y,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic                          is_last,
  input  logic                          queue_full,
  output logic                          push,
  output pip_pkg::entry_ctl_t           push_ctl,
  output logic [10*COORD_BITS-1:0]      push_data
);
  import pip_pkg::*;

  logic                          expect_first;
  logic signed [COORD_BITS-1:0]  first_vx;
  logic signed [COORD_BITS-1:0]  first_vy;
  logic signed [COORD_BITS-1:0]  prev_vx;
  logic signed [COORD_BITS-1:0]  prev_vy;
  logic signed [COORD_BITS-1:0]  held_px;
  logic signed [COORD_BITS-1:0]  held_py;

  logic                          accept;
  logic signed [COORD_BITS-1:0]  cur_px;
  logic signed [COORD_BITS-1:0]  cur_py;
  logic signed [COORD_BITS-1:0]  close_x;
  logic signed [COORD_BITS-1:0]  close_y;
  logic [1:0]                    flags0;
  logic [1:0]                    flags1;
  logic [4*COORD_BITS-1:0]       edge0;
  logic [4*COORD_BITS-1:0]       edge1;

  // {count at once, needs exact test}
  function automatic logic [1:0] edge_flags(
    input logic signed [COORD_BITS-1:0] x0,
    input logic signed [COORD_BITS-1:0] y0,
    input logic signed [COORD_BITS-1:0] x1,
    input logic signed [COORD_BITS-1:0] y1,
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py
  );
    logic span;
    logic flat;
    logic right_of_both;
    span = ((y0 <= py) && (py <= y1)) || ((y1 <= py) && (py <= y0));
    flat = (py == y0) && (py == y1);
    right_of_both = (px >= x0) && (px >= x1);
    return {span && !flat && right_of_both, span && !flat && !right_of_both};
  endfunction

  // lower end first
  function automatic logic [4*COORD_BITS-1:0] order_edge(
    input logic signed [COORD_BITS-1:0] x0,
    input logic signed [COORD_BITS-1:0] y0,
    input logic signed [COORD_BITS-1:0] x1,
    input logic signed [COORD_BITS-1:0] y1
  );
    if (y1 < y0) begin
      return {x1, y1, x0, y0};
    end
    return {x0, y0, x1, y1};
  endfunction

  assign vertex_ready = !queue_full;
  assign accept       = vertex_valid && vertex_ready;

  assign cur_px  = expect_first ? point_x  : held_px;
  assign cur_py  = expect_first ? point_y  : held_py;
  assign close_x = expect_first ? vertex_x : first_vx;
  assign close_y = expect_first ? vertex_y : first_vy;

  assign flags0 = edge_flags(prev_vx, prev_vy, vertex_x, vertex_y, cur_px, cur_py);
  assign flags1 = edge_flags(vertex_x, vertex_y, close_x, close_y, cur_px, cur_py);
  assign edge0  = order_edge(prev_vx, prev_vy, vertex_x, vertex_y);
  assign edge1  = order_edge(vertex_x, vertex_y, close_x, close_y);

  always_comb begin
    push_ctl.first  = expect_first;
    push_ctl.last   = is_last;
    push_ctl.count0 = !expect_first && flags0[1];
    push_ctl.mul0   = !expect_first && flags0[0];
    push_ctl.count1 = is_last && flags1[1];
    push_ctl.mul1   = is_last && flags1[0];
  end

  assign push      = accept;
  assign push_data = {cur_px, cur_py, edge0, edge1};

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_first <= 1'b1;
    end else if (accept) begin
      expect_first <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (expect_first) begin
        first_vx <= vertex_x;
        first_vy <= vertex_y;
        held_px  <= point_x;
        held_py  <= point_y;
      end
      prev_vx <= vertex_x;
      prev_vy <= vertex_y;
    end
  end

`ifndef SYNTHESIS
  // a closing vertex always rearms the capture of the next polygon
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> expect_first)
    else $error("front did not rearm after closing vertex");
`endif

endmodule

// ===== design/pip_queue.sv =====
// short edge queue between front and back parts
// depends on pip_pkg
module pip_queue #(
  parameter int WIDTH = 10 * pip_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pip_pkg::entry_ctl_t  push_ctl,
  input  logic [WIDTH-1:0]     push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output pip_pkg::entry_ctl_t  head_ctl,
  output logic [WIDTH-1:0]     head_data
);
  import pip_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  entry_ctl_t          ctl_mem  [QUEUE_DEPTH];
  logic [WIDTH-1:0]    data_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = (count == CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_ctl   = ctl_mem[rd_ptr];
  assign head_data  = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= push_ctl;
      data_mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // no write into a full queue, no read from an empty one
  assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("edge queue overflow or underflow");
`endif

endmodule

// ===== design/pip_edge_test.sv =====
// one edge test lane: exact crossing compare via split multiplies
// no package use beyond the default width
module pip_edge_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  input  logic                          count,
  input  logic                          mul,
  output logic                          toggle
);

  localparam int DW = COORD_BITS + 1;
  localparam int H  = (DW + 1) / 2;
  localparam int MW = 2 * H;
  localparam int PW = 4 * H;

  // stage 1: differences
  logic [DW-1:0] dx1, ex1, dy1, ey1;
  logic          count1, mul1;
  // stage 2: magnitudes and signs
  logic [MW-1:0] a1_2, b1_2, a2_2, b2_2;
  logic          s1_2, s2_2, count2, mul2;
  // stage 3: partial products
  logic [MW-1:0] ll1, lh1, hl1, hh1, ll2, lh2, hl2, hh2;
  logic          s1_3, s2_3, count3, mul3;
  // stage 4: full products
  logic [PW-1:0] p1, p2;
  logic          s1_4, s2_4, count4, mul4;

  logic n1, n2, less;

  function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [PW-1:0] combine(
    input logic [MW-1:0] ll,
    input logic [MW-1:0] lh,
    input logic [MW-1:0] hl,
    input logic [MW-1:0] hh
  );
    logic [MW:0] mid;
    mid = {1'b0, lh} + {1'b0, hl};
    return {hh, ll} + (PW'(mid) << H);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dx1    <= {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
      ex1    <= {px[COORD_BITS-1], px} - {ax[COORD_BITS-1], ax};
      dy1    <= {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
      ey1    <= {py[COORD_BITS-1], py} - {ay[COORD_BITS-1], ay};
      count1 <= count;
      mul1   <= mul;

      a1_2   <= MW'(magnitude(dx1));
      b1_2   <= MW'(ey1);
      a2_2   <= MW'(magnitude(ex1));
      b2_2   <= MW'(dy1);
      s1_2   <= dx1[DW-1];
      s2_2   <= ex1[DW-1];
      count2 <= count1;
      mul2   <= mul1;

      ll1    <= MW'(a1_2[H-1:0])  * MW'(b1_2[H-1:0]);
      lh1    <= MW'(a1_2[H-1:0])  * MW'(b1_2[MW-1:H]);
      hl1    <= MW'(a1_2[MW-1:H]) * MW'(b1_2[H-1:0]);
      hh1    <= MW'(a1_2[MW-1:H]) * MW'(b1_2[MW-1:H]);
      ll2    <= MW'(a2_2[H-1:0])  * MW'(b2_2[H-1:0]);
      lh2    <= MW'(a2_2[H-1:0])  * MW'(b2_2[MW-1:H]);
      hl2    <= MW'(a2_2[MW-1:H]) * MW'(b2_2[H-1:0]);
      hh2    <= MW'(a2_2[MW-1:H]) * MW'(b2_2[MW-1:H]);
      s1_3   <= s1_2;
      s2_3   <= s2_2;
      count3 <= count2;
      mul3   <= mul2;

      p1     <= combine(ll1, lh1, hl1, hh1);
      p2     <= combine(ll2, lh2, hl2, hh2);
      s1_4   <= s1_3;
      s2_4   <= s2_3;
      count4 <= count3;
      mul4   <= mul3;
    end
  end

  // signed compare of (sign, magnitude) pairs, zero counts as positive
  always_comb begin
    n1 = s1_4 && (p1 != '0);
    n2 = s2_4 && (p2 != '0);
    if (n1 != n2) begin
      less = n1;
    end else if (n1) begin
      less = (p1 > p2);
    end else begin
      less = (p1 < p2);
    end
    toggle = count4 || (mul4 && less);
  end

endmodule

// ===== design/pip_back.sv =====
// back part: edge test lanes u_lane0 and u_lane1, parity accumulation and result register
// depends on pip_pkg and pip_edge_test
module pip_back #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  pip_pkg::entry_ctl_t       head_ctl,
  input  logic [10*COORD_BITS-1:0]  head_data,
  output logic                      pop,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      inside_res
);
  import pip_pkg::*;

  localparam int CB = COORD_BITS;

  logic                    en;
  logic [EDGE_LATENCY-1:0] stg_valid;
  logic [EDGE_LATENCY-1:0] stg_first;
  logic [EDGE_LATENCY-1:0] stg_last;
  logic                    parity;
  logic                    parity_next;
  logic                    tog0;
  logic                    tog1;

  // whole back pipeline moves unless a result waits to be taken
  assign en  = !result_valid || result_ready;
  assign pop = head_valid && en;

  pip_edge_test #(.COORD_BITS(COORD_BITS)) u_lane0 (
    .clk    (clk),
    .en     (en),
    .px     (head_data[10*CB-1 -: CB]),
    .py     (head_data[9*CB-1  -: CB]),
    .ax     (head_data[8*CB-1  -: CB]),
    .ay     (head_data[7*CB-1  -: CB]),
    .bx     (head_data[6*CB-1  -: CB]),
    .by     (head_data[5*CB-1  -: CB]),
    .count  (head_ctl.count0),
    .mul    (head_ctl.mul0),
    .toggle (tog0)
  );

  pip_edge_test #(.COORD_BITS(COORD_BITS)) u_lane1 (
    .clk    (clk),
    .en     (en),
    .px     (head_data[10*CB-1 -: CB]),
    .py     (head_data[9*CB-1  -: CB]),
    .ax     (head_data[4*CB-1  -: CB]),
    .ay     (head_data[3*CB-1  -: CB]),
    .bx     (head_data[2*CB-1  -: CB]),
    .by     (head_data[CB-1    -: CB]),
    .count  (head_ctl.count1),
    .mul    (head_ctl.mul1),
    .toggle (tog1)
  );

  assign parity_next = (stg_first[EDGE_LATENCY-1] ? 1'b0 : parity) ^ tog0 ^ tog1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid    <= '0;
      parity       <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      stg_valid    <= {stg_valid[EDGE_LATENCY-2:0], head_valid};
      if (stg_valid[EDGE_LATENCY-1]) begin
        parity <= parity_next;
      end
      result_valid <= stg_valid[EDGE_LATENCY-1] && stg_last[EDGE_LATENCY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_first <= {stg_first[EDGE_LATENCY-2:0], head_ctl.first};
      stg_last  <= {stg_last[EDGE_LATENCY-2:0], head_ctl.last};
      if (stg_valid[EDGE_LATENCY-1] && stg_last[EDGE_LATENCY-1]) begin
        inside_res <= parity_next;
      end
    end
  end

`ifndef SYNTHESIS
  // a new result only ever comes from a closing entry leaving the lanes
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stg_valid[EDGE_LATENCY-1] && stg_last[EDGE_LATENCY-1]))
    else $error("result raised without a closing entry");
  // a stalled result holds the pipeline still
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(stg_valid) && $stable(parity))
    else $error("back pipeline moved under a stalled result");
`endif

endmodule
